FILE: hdl/wrapped_bilinear_texture_sampler_core_assert.svh
// Assertion helpers shared by the sampler RTL.
// Both macros sample on clk_i and stay quiet while rst_ni is low.
`ifndef WRAPPED_BILINEAR_TEXTURE_SAMPLER_CORE_ASSERT_SVH
`define WRAPPED_BILINEAR_TEXTURE_SAMPLER_CORE_ASSERT_SVH

// Same-cycle implication.
`define WBTS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sampler assertion failed");

// Next-cycle implication.
`define WBTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sampler assertion failed");

`endif

FILE: hdl/wbts_pkg.sv
package wbts_pkg;

  // Texture geometry
  localparam int MaxSide = 256;
  localparam int SideW   = $clog2(MaxSide + 1);
  localparam int CoordW  = $clog2(MaxSide);
  localparam int AddrW   = 2 * CoordW;

  // Word formats
  localparam int FracW     = 16;
  localparam int ByteW     = 8;
  localparam int PatternW  = 4 * ByteW;
  localparam int TexelW    = PatternW + ByteW;
  localparam int ResultW   = 18;

  // Action codes
  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_PATTERN = 2'd1;
  localparam logic [1:0] ACT_MASK    = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_SIDE    = 2'd0;
  localparam logic [1:0] CFG_PATTERN = 2'd1;
  localparam logic [1:0] CFG_MASK    = 2'd2;

  // Step strobes from the sequencer to the filter datapath
  typedef struct packed {
    logic       load;
    logic       mul;
    logic       loc;
    logic       row;
    logic       rd;
    logic [1:0] rd_sel;
    logic       div1;
    logic       div2;
  } wbts_ctl_t;

endpackage

FILE: hdl/wbts_texmem.sv
module wbts_texmem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [wbts_pkg::AddrW-1:0]    addr_i,
  input  logic [wbts_pkg::TexelW-1:0]   wdata_i,
  output logic [wbts_pkg::TexelW-1:0]   rdata_o
);
  import wbts_pkg::*;

  localparam int Depth = 1 << AddrW;

  logic [TexelW-1:0] mem [Depth];
  logic [TexelW-1:0] rdata_q;

  // Single port: write or read one texel per cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/wbts_filter.sv
module wbts_filter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wbts_pkg::wbts_ctl_t                ctl_i,
  input  logic [1:0]                         action_i,
  input  logic [1:0]                         channel_i,
  input  logic [wbts_pkg::FracW-1:0]         frac_u_i,
  input  logic [wbts_pkg::FracW-1:0]         frac_v_i,
  input  logic [wbts_pkg::SideW-1:0]         side_i,
  input  logic [wbts_pkg::TexelW-1:0]        rdata_i,
  output logic [wbts_pkg::AddrW-1:0]         rd_addr_o,
  output logic signed [wbts_pkg::ResultW-1:0] result_o
);
  import wbts_pkg::*;

  localparam int ProdW   = FracW + SideW;
  localparam int TW      = ProdW + 1;
  localparam int RowW    = CoordW + SideW;
  localparam int WeightW = FracW + 1;
  localparam int P1W     = ByteW + WeightW;
  localparam int P2W     = P1W + WeightW;
  localparam int AccW    = 2 * FracW + ByteW;
  localparam int SumW    = AccW + 1;
  localparam int RndShift = 2 * FracW - 16;
  localparam int NegShift = 2 * FracW - 9;
  localparam int DivW    = 24;
  localparam int RecW    = 26;
  localparam int RecShift = 32;
  localparam int QW      = ResultW - 1;

  localparam logic [WeightW-1:0] One = {1'b1, {FracW{1'b0}}};
  localparam logic signed [TW-1:0] Half = {{(TW - FracW){1'b0}}, 1'b1, {(FracW - 1){1'b0}}};
  localparam logic [SumW-1:0] PatBias  = SumW'(255) << (RndShift - 1);
  localparam logic [SumW-1:0] MaskBias = SumW'(127) << (RndShift - 1);
  localparam logic [SumW-1:0] NegBias  = SumW'(1) << (NegShift - 1);
  localparam logic [SumW-1:0] Neutral  = SumW'(128) << (2 * FracW);
  localparam logic [RecW-1:0] Rec255 = 26'd16843009;
  localparam logic [RecW-1:0] Rec127 = 26'd33818640;
  localparam logic [ByteW-1:0] Div255 = 8'd255;
  localparam logic [ByteW-1:0] Div127 = 8'd127;

  localparam logic [1:0] MODE_PAT  = 2'd0;
  localparam logic [1:0] MODE_MPOS = 2'd1;
  localparam logic [1:0] MODE_MNEG = 2'd2;

  typedef struct packed {
    logic [CoordW-1:0] p0;
    logic [CoordW-1:0] p1;
    logic [FracW-1:0]  frac;
  } loc_t;

  // Wrap floor(t) into 0..n-1; t lies in -1..n-1 after the integer part drops out
  function automatic loc_t wrap_coord(input logic signed [TW-1:0] t,
                                      input logic [SideW-1:0] n);
    loc_t r;
    logic [SideW-1:0] m;
    logic [SideW-1:0] m1;
    m = t[TW-1] ? (n - 1'b1) : {1'b0, t[FracW +: CoordW]};
    m1 = m + 1'b1;
    r.p0 = m[CoordW-1:0];
    r.p1 = (m1 == n) ? '0 : m1[CoordW-1:0];
    r.frac = t[FracW-1:0];
    return r;
  endfunction

  logic                     is_mask_q;
  logic [1:0]               chan_q;
  logic [FracW-1:0]         fu_q, fv_q;
  logic [SideW-1:0]         n_q;
  logic signed [TW-1:0]     tu_q, tv_q;
  logic [ProdW-1:0]         pu, pv;
  loc_t                     lu, lv;
  logic [CoordW-1:0]        x0_q, x1_q, y0_q, y1_q;
  logic [FracW-1:0]         fx_q, fy_q;
  logic [RowW-1:0]          row0, row1;
  logic [AddrW-1:0]         base0_q, base1_q;
  logic                     cap_v_q, acc_v_q;
  logic [1:0]               cap_sel_q, acc_sel_q;
  logic [ByteW-1:0]         tex_byte;
  logic [WeightW-1:0]       wx, wy;
  logic [P1W-1:0]           p1_d, p1_q;
  logic [P2W-1:0]           p2;
  logic [AccW-1:0]          acc_q;
  logic [SumW-1:0]          acc_x, sum_pat, sum_pos, sum_neg;
  logic [DivW-1:0]          t_d, t_q;
  logic [1:0]               mode_d, mode_q;
  logic [RecW-1:0]          recip;
  logic [DivW+RecW-1:0]     qprod;
  logic [QW-1:0]            qe_q, q;
  logic [ByteW-1:0]         dsel;
  logic [DivW-1:0]          qd, rem;

  // Capture the sample fields
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      is_mask_q <= (action_i == ACT_MASK);
      chan_q    <= channel_i;
      fu_q      <= frac_u_i;
      fv_q      <= frac_v_i;
      n_q       <= side_i;
    end
  end

  // Scale the fractional coordinate by the side and step back half a texel
  assign pu = ProdW'(fu_q) * ProdW'(n_q);
  assign pv = ProdW'(fv_q) * ProdW'(n_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      tu_q <= $signed({1'b0, pu}) - Half;
      tv_q <= $signed({1'b0, pv}) - Half;
    end
  end

  // Wrap both axes to the texel pair and fraction
  assign lu = wrap_coord(tu_q, n_q);
  assign lv = wrap_coord(tv_q, n_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.loc) begin
      x0_q <= lu.p0;
      x1_q <= lu.p1;
      fx_q <= lu.frac;
      y0_q <= lv.p0;
      y1_q <= lv.p1;
      fy_q <= lv.frac;
    end
  end

  // Row base addresses; the index stays below side*side
  assign row0 = RowW'(y0_q) * RowW'(n_q);
  assign row1 = RowW'(y1_q) * RowW'(n_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.row) begin
      base0_q <= row0[AddrW-1:0];
      base1_q <= row1[AddrW-1:0];
    end
  end

  // Texel order: (x0,y0), (x1,y0), (x0,y1), (x1,y1)
  assign rd_addr_o = (ctl_i.rd_sel[1] ? base1_q : base0_q)
                   + AddrW'(ctl_i.rd_sel[0] ? x1_q : x0_q);

  // Pick the byte of the returned texel
  always_comb begin
    if (is_mask_q) begin
      tex_byte = rdata_i[TexelW-1 -: ByteW];
    end else begin
      tex_byte = rdata_i[chan_q * ByteW +: ByteW];
    end
  end

  assign wx   = cap_sel_q[0] ? {1'b0, fx_q} : One - {1'b0, fx_q};
  assign wy   = acc_sel_q[1] ? {1'b0, fy_q} : One - {1'b0, fy_q};
  assign p1_d = P1W'(tex_byte) * P1W'(wx);
  assign p2   = P2W'(p1_q) * P2W'(wy);

  // Track read returns through the two weighting stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_v_q <= 1'b0;
      acc_v_q <= 1'b0;
    end else begin
      cap_v_q <= ctl_i.rd;
      acc_v_q <= cap_v_q;
    end
  end

  // Weight each texel and accumulate
  always_ff @(posedge clk_i) begin
    cap_sel_q <= ctl_i.rd_sel;
    acc_sel_q <= cap_sel_q;
    if (cap_v_q) begin
      p1_q <= p1_d;
    end
    if (ctl_i.load) begin
      acc_q <= '0;
    end else if (acc_v_q) begin
      acc_q <= acc_q + p2[AccW-1:0];
    end
  end

  // Round the sum into a dividend for the constant divider
  assign acc_x   = {1'b0, acc_q};
  assign sum_pat = acc_x + PatBias;
  assign sum_pos = (acc_x - Neutral) + MaskBias;
  assign sum_neg = (Neutral - acc_x) + NegBias;

  always_comb begin
    if (!is_mask_q) begin
      t_d    = DivW'(sum_pat >> RndShift);
      mode_d = MODE_PAT;
    end else if (acc_x >= Neutral) begin
      t_d    = DivW'(sum_pos >> RndShift);
      mode_d = MODE_MPOS;
    end else begin
      t_d    = DivW'(sum_neg >> NegShift);
      mode_d = MODE_MNEG;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.div1) begin
      t_q    <= t_d;
      mode_q <= mode_d;
    end
  end

  // Estimate the quotient by reciprocal; it can fall short by one
  assign recip = (mode_q == MODE_MPOS) ? Rec127 : Rec255;
  assign qprod = (DivW + RecW)'(t_q) * (DivW + RecW)'(recip);

  always_ff @(posedge clk_i) begin
    if (ctl_i.div2) begin
      qe_q <= qprod[RecShift +: QW];
    end
  end

  // Correct the estimate and restore the sign
  assign dsel = (mode_q == MODE_MPOS) ? Div127 : Div255;
  assign qd   = DivW'(qe_q) * DivW'(dsel);
  assign rem  = t_q - qd;
  assign q    = (rem >= DivW'(dsel)) ? qe_q + 1'b1 : qe_q;

  always_comb begin
    if (mode_q == MODE_MNEG) begin
      result_o = -$signed({1'b0, t_q[QW-1:0]});
    end else begin
      result_o = $signed({1'b0, q});
    end
  end

endmodule

FILE: hdl/wrapped_bilinear_texture_sampler_core.sv
// Bilinear sampler over a wrapping square texture held in one single-port memory.
// Input channel (in_valid_i/in_ready_o) takes one word per item: a texel write,
// a pattern-channel sample or a mask sample. Output channel (out_valid_o/
// out_ready_i) returns one Q1.16 word for every sample and nothing for writes.
// A write is stored in the cycle it is accepted and the block is ready again
// at once: one write per cycle.
// A sample runs through a fixed sequence: coordinate multiply, wrap, row base,
// four texel reads from the texture memory with two weighting stages behind
// them, and a two-step constant divide. The result enters the output register
// from the DONE state, and the block takes no new item until it has left DONE;
// the four reads through the one memory port and the divider steps set the pace.
// A sample that answers zero (side zero or table absent) goes straight to DONE.
// The configuration port writes side, pattern_present and mask_present with no
// wait; write it only while the block is idle.
// Reset sets side 256, pattern present, mask absent. Texture contents are
// undefined until written.
// When the receiver stalls, the result holds in the output register; the block
// still accepts new items, and a new sample waits in its last step until the
// output register frees.
`include "wrapped_bilinear_texture_sampler_core_assert.svh"

module wrapped_bilinear_texture_sampler_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_index_i,
  input  logic [wbts_pkg::SideW-1:0]            cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            action_i,
  input  logic [wbts_pkg::AddrW-1:0]            texel_index_i,
  input  logic [wbts_pkg::PatternW-1:0]         pattern_word_i,
  input  logic [wbts_pkg::ByteW-1:0]            mask_value_i,
  input  logic [1:0]                            channel_i,
  input  logic signed [31:0]                    coord_u_i,
  input  logic signed [31:0]                    coord_v_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [wbts_pkg::ResultW-1:0]   sample_value_o
);
  import wbts_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_LOC  = 3'd2;
  localparam logic [2:0] ST_ROW  = 3'd3;
  localparam logic [2:0] ST_READ = 3'd4;
  localparam logic [2:0] ST_DIV1 = 3'd5;
  localparam logic [2:0] ST_DIV2 = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  localparam logic [2:0] ReadLast = 3'd5;

  logic [2:0]               state_d, state_q;
  logic [2:0]               cnt_d, cnt_q;
  logic [SideW-1:0]         side_q, n_eff;
  logic                     pat_q, mask_q;
  logic                     accept, zero_d, zero_d_q, zero_q;
  logic                     mem_we;
  logic [AddrW-1:0]         mem_addr, rd_addr;
  logic [TexelW-1:0]        rdata;
  wbts_ctl_t                ctl;
  logic signed [ResultW-1:0] result;
  logic                     out_load, out_valid_d, out_valid_q;
  logic signed [ResultW-1:0] sample_value_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SideW'(MaxSide);
      pat_q  <= 1'b1;
      mask_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SIDE:    side_q <= cfg_data_i;
        CFG_PATTERN: pat_q  <= cfg_data_i[0];
        CFG_MASK:    mask_q <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign n_eff      = (side_q > SideW'(MaxSide)) ? SideW'(MaxSide) : side_q;
  assign zero_d     = (n_eff == '0)
                    || ((action_i == ACT_PATTERN) && !pat_q)
                    || ((action_i == ACT_MASK) && !mask_q);
  assign mem_we     = accept && (action_i == ACT_WRITE);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    zero_d_q = zero_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          unique case (action_i) inside
            ACT_PATTERN, ACT_MASK: begin
              zero_d_q = zero_d;
              state_d  = zero_d ? ST_DONE : ST_MUL;
            end
            ACT_WRITE, ACT_NONE: ;
          endcase
        end
      end
      ST_MUL:  state_d = ST_LOC;
      ST_LOC:  state_d = ST_ROW;
      ST_ROW:  state_d = ST_READ;
      ST_READ: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ReadLast) begin
          state_d = ST_DIV1;
        end
      end
      ST_DIV1: state_d = ST_DIV2;
      ST_DIV2: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      zero_q  <= zero_d_q;
    end
  end

  // Step strobes for the datapath; reads issue while the READ counter is below four
  always_comb begin
    ctl.load   = accept;
    ctl.mul    = (state_q == ST_MUL);
    ctl.loc    = (state_q == ST_LOC);
    ctl.row    = (state_q == ST_ROW);
    ctl.rd     = (state_q == ST_READ) && !cnt_q[2];
    ctl.rd_sel = cnt_q[1:0];
    ctl.div1   = (state_q == ST_DIV1);
    ctl.div2   = (state_q == ST_DIV2);
  end

  // Writes own the memory port only in idle, so reads never collide with them
  assign mem_addr = mem_we ? texel_index_i : rd_addr;

  wbts_texmem u_texmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i ({mask_value_i, pattern_word_i}),
    .rdata_o (rdata)
  );

  // Only the fraction matters: the integer period drops out of the wrap
  wbts_filter u_filter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .action_i  (action_i),
    .channel_i (channel_i),
    .frac_u_i  (coord_u_i[FracW-1:0]),
    .frac_v_i  (coord_v_i[FracW-1:0]),
    .side_i    (n_eff),
    .rdata_i   (rdata),
    .rd_addr_o (rd_addr),
    .result_o  (result)
  );

  // Output register
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_value_q <= zero_q ? '0 : result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = sample_value_q;

  `WBTS_ASSERT_IMPL(a_out_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE)
  `WBTS_ASSERT_IMPL(a_read_count, state_q == ST_READ, cnt_q <= ReadLast)
  `WBTS_ASSERT_IMPL(a_result_range, out_valid_q, (sample_value_q >= -18'sd65536) && (sample_value_q <= 18'sd65536))
  `WBTS_ASSERT_NEXT(a_done_waits, (state_q == ST_DONE) && out_valid_q && !out_ready_i, (state_q == ST_DONE) && $stable(sample_value_q))
  `WBTS_ASSERT_IMPL(a_write_idle, mem_we, state_q == ST_IDLE)

endmodule
